// File: rtl/core/hprng_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hprng_pkg
// Shared types, constants and the seed mixing hash for the hashed-seed
// rotate-add generator.
// ----------------------------------------------------------------------------
package hprng_pkg;

    localparam int WORD_W    = 32;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_SEED_LOW  = 2'd0;
    localparam logic [1:0] REG_SEED_HIGH = 2'd1;
    localparam logic [1:0] REG_SEED_MODE = 2'd2;

    // Hash constants
    localparam logic [WORD_W-1:0] MIX_C0 = 32'h7ed5_5d16;
    localparam logic [WORD_W-1:0] MIX_C1 = 32'hc761_c23c;
    localparam logic [WORD_W-1:0] MIX_C2 = 32'h1656_67b1;
    localparam logic [WORD_W-1:0] MIX_C3 = 32'hd3a2_646c;
    localparam logic [WORD_W-1:0] MIX_C4 = 32'hfd70_46c5;
    localparam logic [WORD_W-1:0] MIX_C5 = 32'hb55a_4f09;

    // Single-seed mode XOR constants
    localparam logic [WORD_W-1:0] SINGLE_LOW_XOR  = 32'h0520_af59;
    localparam logic [WORD_W-1:0] SINGLE_HIGH_XOR = 32'h4961_6e42;

    typedef logic [2:0] t_mix_idx;

    localparam t_mix_idx MIX_FIRST = 3'd0;
    localparam t_mix_idx MIX_LAST  = 3'd5;

    typedef struct packed {
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
    } t_seed_words;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] raw;
        logic [WORD_W-1:0] diff;
        logic [WORD_W-1:0] min;
        logic              err;
    } t_scale_in;

    // One step of the six-step integer mixing hash
    function automatic logic [WORD_W-1:0] mix_step(input logic [WORD_W-1:0] v,
                                                   input t_mix_idx          idx);
        logic [WORD_W-1:0] r;
        case (idx)
            3'd0:    r = (v + MIX_C0) + (v << 12);
            3'd1:    r = (v ^ MIX_C1) ^ (v >> 19);
            3'd2:    r = (v + MIX_C2) + (v << 5);
            3'd3:    r = (v + MIX_C3) ^ (v << 9);
            3'd4:    r = (v + MIX_C4) + (v << 3);
            3'd5:    r = (v ^ MIX_C5) ^ (v >> 16);
            default: r = v;
        endcase
        return r;
    endfunction

    // Full hash, used for elaboration-time reset values only
    function automatic logic [WORD_W-1:0] mix32(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = v;
        for (int k = 0; k <= int'(MIX_LAST); k++) begin
            r = mix_step(r, t_mix_idx'(k));
        end
        return r;
    endfunction

    localparam logic [WORD_W-1:0] RESET_HASH      = mix32(32'd0);
    localparam logic [WORD_W-1:0] RESET_LOW_WORD  = RESET_HASH ^ SINGLE_LOW_XOR;
    localparam logic [WORD_W-1:0] RESET_HIGH_WORD = RESET_HASH ^ SINGLE_HIGH_XOR;

endpackage
`default_nettype wire

// File: rtl/core/hprng_seed.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hprng_seed
// APB seed registers and an iterative hash sequencer: one mixing step per
// cycle on both seeds, then the mode-dependent seed words are latched.
// ----------------------------------------------------------------------------
module hprng_seed (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hprng_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [hprng_pkg::PDATA_W-1:0]   pwdata,
    output logic      [hprng_pkg::PDATA_W-1:0]   prdata,
    output logic                                 pready,
    output logic                                 o_busy,
    output hprng_pkg::t_seed_words               o_seed
);

    logic [hprng_pkg::WORD_W-1:0] r_seed_low;
    logic [hprng_pkg::WORD_W-1:0] r_seed_high;
    logic                         r_seed_mode;
    logic                         r_busy;
    hprng_pkg::t_mix_idx          r_step;
    hprng_pkg::t_seed_words       r_work;
    hprng_pkg::t_seed_words       r_hash;

    hprng_pkg::t_seed_words       n_work;
    hprng_pkg::t_seed_words       n_hash;
    hprng_pkg::t_seed_words       mix_in;
    logic                         wr_en;
    logic                         wr_known;
    logic [1:0]                   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        wr_known = 1'b0;
        prdata   = '0;
        unique case (reg_idx)
            hprng_pkg::REG_SEED_LOW: begin
                wr_known = 1'b1;
                prdata   = r_seed_low;
            end
            hprng_pkg::REG_SEED_HIGH: begin
                wr_known = 1'b1;
                prdata   = r_seed_high;
            end
            hprng_pkg::REG_SEED_MODE: begin
                wr_known = 1'b1;
                prdata   = {{(hprng_pkg::PDATA_W-1){1'b0}}, r_seed_mode};
            end
            default: begin
                wr_known = 1'b0;
                prdata   = '0;
            end
        endcase
    end

    // First step works on the seed registers, later steps on the work words
    always_comb begin
        if (r_step == hprng_pkg::MIX_FIRST) begin
            mix_in.lo = r_seed_low;
            mix_in.hi = r_seed_high;
        end else begin
            mix_in = r_work;
        end
        n_work.lo = hprng_pkg::mix_step(mix_in.lo, r_step);
        n_work.hi = hprng_pkg::mix_step(mix_in.hi, r_step);
        if (r_seed_mode) begin
            n_hash = n_work;
        end else begin
            n_hash.lo = n_work.lo ^ hprng_pkg::SINGLE_LOW_XOR;
            n_hash.hi = n_work.lo ^ hprng_pkg::SINGLE_HIGH_XOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_low  <= '0;
            r_seed_high <= '0;
            r_seed_mode <= 1'b0;
            r_busy      <= 1'b0;
            r_step      <= hprng_pkg::MIX_FIRST;
            r_hash.lo   <= hprng_pkg::RESET_LOW_WORD;
            r_hash.hi   <= hprng_pkg::RESET_HIGH_WORD;
        end else begin
            if (r_busy) begin
                if (r_step == hprng_pkg::MIX_LAST) begin
                    r_busy <= 1'b0;
                    r_hash <= n_hash;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
            // A fresh write restarts the hash from its first step
            if (wr_en && wr_known) begin
                r_busy <= 1'b1;
                r_step <= hprng_pkg::MIX_FIRST;
                unique case (reg_idx)
                    hprng_pkg::REG_SEED_LOW:  r_seed_low  <= pwdata;
                    hprng_pkg::REG_SEED_HIGH: r_seed_high <= pwdata;
                    hprng_pkg::REG_SEED_MODE: r_seed_mode <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_work <= n_work;
        end
    end

    assign o_busy = r_busy;
    assign o_seed = r_hash;

endmodule
`default_nettype wire

// File: rtl/core/hprng_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hprng_scale
// Range scaling: registered 32x32 product of raw word and span-1, then the
// top half of raw*span added to the minimum (the minimum alone on a range error) into the output register.
// ----------------------------------------------------------------------------
module hprng_scale (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire hprng_pkg::t_scale_in              i_item,
    output logic                                   o_valid,
    output logic      [hprng_pkg::M_TDATA_W-1:0]   o_tdata
);

    localparam int W = hprng_pkg::WORD_W;

    logic             r_c_valid;
    logic [2*W-1:0]   r_c_prod;
    logic [W-1:0]     r_c_raw;
    logic [W-1:0]     r_c_min;
    logic             r_c_err;

    logic             r_out_valid;
    logic [W-1:0]     r_out_raw;
    logic [W-1:0]     r_out_value;
    logic             r_out_err;

    logic [2*W-1:0]   scaled;
    logic [W-1:0]     n_value;

    // raw * (diff + 1) = raw * diff + raw, never beyond 64 bits
    always_comb begin
        scaled = r_c_prod + {{W{1'b0}}, r_c_raw};
        if (r_c_err) begin
            n_value = r_c_min;
        end else begin
            n_value = r_c_min + scaled[2*W-1:W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid   <= i_item.valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_prod    <= (2*W)'(i_item.raw) * (2*W)'(i_item.diff);
            r_c_raw     <= i_item.raw;
            r_c_min     <= i_item.min;
            r_c_err     <= i_item.err;
            r_out_raw   <= r_c_raw;
            r_out_value <= n_value;
            r_out_err   <= r_c_err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_tdata = {{(hprng_pkg::M_TDATA_W-2*W-1){1'b0}},
                      r_out_err, r_out_value, r_out_raw};

endmodule
`default_nettype wire

// File: rtl/core/hashed_seed_rotate_add_prng.sv
// Result path: input register, state register, product register, output register.
// Throughput: one item per cycle when not stalled by m_tready or a seed hash; the
// state rotate and two adds sit in one stage. A seed register write re-runs the
// 6-step hash, one step per cycle, holding s_tready low until it completes.
// Reset loads both state words from the hash of zero seeds in single mode.
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_seed_rotate_add_prng
// Rotate-add pseudo-random generator with hashed seeding and a ranged
// integer output.
// ----------------------------------------------------------------------------
module hashed_seed_rotate_add_prng (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // s_tdata: [0] restart, [32:1] range_min, [64:33] range_max, [71:65] zero
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [hprng_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: [31:0] raw_word, [63:32] ranged_value, [64] range_error,
    //          [71:65] zero
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [hprng_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [hprng_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [hprng_pkg::PDATA_W-1:0]     pwdata,
    output logic      [hprng_pkg::PDATA_W-1:0]     prdata,
    output logic                                   pready
);

    localparam int W = hprng_pkg::WORD_W;

    logic                    hash_busy;
    hprng_pkg::t_seed_words  seed;

    logic                    r_a_valid;
    logic                    r_a_restart;
    logic [W-1:0]            r_a_min;
    logic [W-1:0]            r_a_max;

    logic [W-1:0]            r_high;
    logic [W-1:0]            r_low;

    hprng_pkg::t_scale_in    r_b;
    hprng_pkg::t_scale_in    n_b;

    logic                    en;
    logic                    out_valid;
    logic [W-1:0]            cur_high;
    logic [W-1:0]            cur_low;
    logic [W-1:0]            n_high;
    logic [W-1:0]            n_low;

    hprng_seed u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_busy  (hash_busy),
        .o_seed  (seed)
    );

    // Whole pipeline advances unless a finished result is held
    assign en       = !out_valid || m_tready;
    assign s_tready = en && !hash_busy;

    always_comb begin
        if (r_a_restart) begin
            cur_high = seed.hi;
            cur_low  = seed.lo;
        end else begin
            cur_high = r_high;
            cur_low  = r_low;
        end
        n_high = {cur_high[15:0], cur_high[31:16]} + cur_low;
        n_low  = cur_low + n_high;

        n_b.valid = r_a_valid;
        n_b.raw   = n_high;
        n_b.diff  = r_a_max - r_a_min;
        n_b.min   = r_a_min;
        n_b.err   = $signed(r_a_max) < $signed(r_a_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b       <= '0;
            r_high    <= hprng_pkg::RESET_HIGH_WORD;
            r_low     <= hprng_pkg::RESET_LOW_WORD;
        end else if (en) begin
            r_a_valid <= s_tvalid && s_tready;
            r_b       <= n_b;
            // advance the state only for a real item
            if (r_a_valid) begin
                r_high <= n_high;
                r_low  <= n_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_restart <= s_tdata[0];
            r_a_min     <= s_tdata[32:1];
            r_a_max     <= s_tdata[64:33];
        end
    end

    hprng_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_item  (r_b),
        .o_valid (out_valid),
        .o_tdata (m_tdata)
    );

    assign m_tvalid = out_valid;

endmodule
`default_nettype wire
